### hw/rtl/csik_pkg.sv
package csik_pkg;

  // one request to the shared multiplier: |a|*|b| >> sh, saturated, signed
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } mul_req_t;

  localparam logic signed [63:0] LN2_Q32       = 64'sd2977044472;
  localparam logic signed [63:0] STEP_GAIN_Q26 = 64'sd13421773;
  localparam logic signed [63:0] TOL_Q48       = 64'sd281474976711;
  localparam logic signed [63:0] INV_2PI_Q32   = 64'sd683565276;
  localparam logic signed [63:0] X_LIMIT       = 64'sd536870912;
  localparam logic signed [63:0] ONE_Q24       = 64'sd16777216;
  localparam logic signed [63:0] CNT_MAX       = 64'sd8388607;
  localparam logic signed [63:0] CNT_MIN       = -64'sd8388608;
  localparam logic signed [63:0] PHI0_Q12_UM   = 64'sd29009123072;
  localparam logic signed [63:0] C_Q56_UM      = 64'sd6104587950;

  localparam int unsigned NUM_REGS = 8;
  localparam logic [2:0] REG_LEFT_HOME  = 3'd6;
  localparam logic [2:0] REG_RIGHT_HOME = 3'd7;

endpackage

### hw/rtl/csik_mul.sv
module csik_mul import csik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mul_req_t           req,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [5:0]   sh_r;
  logic [127:0] acc_r;
  logic [1:0]   ph_r;
  logic         busy_r, fin_r, done_r;
  logic signed [63:0] res_r;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] sr;
  logic [63:0]  mag;

  assign ah = ph_r[1] ? ua_r[63:32] : ua_r[31:0];
  assign bh = ph_r[0] ? ub_r[63:32] : ub_r[31:0];
  assign pp = 64'(ah) * 64'(bh);

  always_comb begin
    unique case (ph_r)
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  assign sr  = acc_r >> sh_r;
  assign mag = (|sr[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : sr[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        ua_r   <= req.a[63] ? 64'd0 - 64'(req.a) : 64'(req.a);
        ub_r   <= req.b[63] ? 64'd0 - 64'(req.b) : 64'(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        sh_r   <= req.sh;
        acc_r  <= '0;
        ph_r   <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_sh;
        ph_r  <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        res_r  <= neg_r ? -$signed(mag) : $signed(mag);
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### hw/rtl/csik_sqrt.sv
module csik_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem_r, r_r;
  logic [4:0]  k_r;
  logic        busy_r, done_r;
  logic [31:0] root_r;
  logic [63:0] b, trial;

  assign b     = 64'd1 << {k_r, 1'b0};
  assign trial = r_r + b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= arg;
        r_r    <= '0;
        k_r    <= 5'd31;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          r_r   <= (r_r >> 1) + b;
          if (k_r == 5'd0) root_r <= 32'((r_r >> 1) + b);
        end else begin
          r_r <= r_r >> 1;
          if (k_r == 5'd0) root_r <= 32'(r_r >> 1);
        end
        k_r <= k_r - 5'd1;
        if (k_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hw/rtl/cable_spool_inverse_kinematics.sv
// the wire length and the home spiral term are worked out first, then the descent steps
// run, for each of the two wires in turn; one request at a time
// the work goes through the shared 32x32 multiplier (4 partial products per 64 bit
// product) and the square root unit (one bit pair per cycle)
// reset (rst_n low, synchronous) clears the control and configuration registers and idles the sequencer
module cable_spool_inverse_kinematics import csik_pkg::*; #(
  parameter int WIRE_DIAMETER_UM = 1000,
  parameter int MAX_ITERATIONS   = 100,
  parameter int COUNTS_PER_TURN  = 7400
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // target_x, target_y, target_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_count, right_count
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // spiral constants follow from the wire diameter
  localparam logic signed [63:0] C_Q56   = C_Q56_UM * 64'(WIRE_DIAMETER_UM);
  localparam logic signed [63:0] P0_Q12  = PHI0_Q12_UM / 64'(WIRE_DIAMETER_UM);
  localparam int                 ITER_W  = $clog2(MAX_ITERATIONS + 1);
  localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_WL      = 24'h000002,
    S_WL_ACC  = 24'h000004,
    S_WL_DONE = 24'h000008,
    S_G       = 24'h000010,
    S_G_RT    = 24'h000020,
    S_G_LN0   = 24'h000040,
    S_G_NORM  = 24'h000080,
    S_G_SQ    = 24'h000100,
    S_G_PS    = 24'h000200,
    S_G_END   = 24'h000400,
    S_L_ES    = 24'h000800,
    S_L_V     = 24'h001000,
    S_L_DX    = 24'h002000,
    S_L_X     = 24'h004000,
    S_L_ERR   = 24'h008000,
    S_L_TOL   = 24'h010000,
    S_L_NEXT  = 24'h020000,
    S_CNT     = 24'h040000,
    S_CNT2    = 24'h080000,
    S_CNT3    = 24'h100000,
    S_DONE    = 24'h200000,
    S_MWAIT   = 24'h400000,
    S_SWAIT   = 24'h800000
  } state_t;

  // configuration registers
  logic [31:0] pul_r [6];
  logic [30:0] home_r [2];

  // sequencer and datapath registers
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [31:0] t_r [3];
  logic        wire_r, wire_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic signed [63:0] dl_r, dl_nxt, p_r, p_nxt, ash_r, ash_nxt, g0_r, g0_nxt;
  logic signed [63:0] x_r, x_nxt, err_r, err_nxt;
  logic [31:0] s_r, s_nxt;
  logic [32:0] m_r, m_nxt;
  logic signed [6:0] n_r, n_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [4:0]  j_r, j_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic        gsel_r, gsel_nxt;
  logic [23:0] cnt_r [2];
  logic [23:0] cnt_nxt;
  logic        cnt_we;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;

  // shared units
  logic               mul_start, mul_done;
  mul_req_t           mul_req;
  logic signed [63:0] mul_res;
  logic               sqrt_start, sqrt_done;
  logic [63:0]        sqrt_arg;
  logic [31:0]        sqrt_root;

  csik_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  csik_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .arg   (sqrt_arg),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // coordinate difference for the wire length term, and the helpers of the other states
  logic [2:0]         pidx;
  logic signed [32:0] d;
  logic [32:0]        ud;
  logic [31:0]        q;
  logic [63:0]        ap;
  logic [32:0]        m_sq;
  logic [23:0]        frac_sq;
  logic signed [63:0] ln_arg;
  logic signed [64:0] x_diff;
  logic signed [63:0] g_val, err_val;

  assign pidx    = {1'b0, k_r} + (wire_r ? 3'd3 : 3'd0);
  assign d       = $signed({t_r[k_r][31], t_r[k_r]}) - $signed({pul_r[pidx][31], pul_r[pidx]});
  assign ud      = d[32] ? 33'd0 - 33'(d) : 33'(d);
  assign q       = ud[32:1];
  assign ap      = p_r[63] ? 64'd0 - 64'(p_r) : 64'(p_r);
  assign m_sq    = mul_res[31] ? {1'b0, mul_res[32:1]} : mul_res[32:0];
  assign frac_sq = {frac_r[22:0], mul_res[31]};
  assign ln_arg  = ($signed(64'(n_r)) - 64'sd12) * ONE_Q24 + $signed(64'(frac_sq));
  assign x_diff  = $signed({x_r[63], x_r}) - $signed({mul_res[63], mul_res});
  assign g_val   = mul_res + (p_r[63] ? -ash_r : ash_r);
  assign err_val = mul_res - dl_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    wire_nxt      = wire_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    dl_nxt        = dl_r;
    p_nxt         = p_r;
    ash_nxt       = ash_r;
    g0_nxt        = g0_r;
    x_nxt         = x_r;
    err_nxt       = err_r;
    s_nxt         = s_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    frac_nxt      = frac_r;
    j_nxt         = j_r;
    iter_nxt      = iter_r;
    gsel_nxt      = gsel_r;
    cnt_nxt       = '0;
    cnt_we        = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    mul_req       = '0;
    sqrt_start    = 1'b0;
    sqrt_arg      = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          wire_nxt  = 1'b0;
          k_nxt     = 2'd0;
          sum_nxt   = '0;
          state_nxt = S_WL;
        end
      end
      // sum of floor(d^2/4) over the three axes
      S_WL: begin
        mul_start   = 1'b1;
        mul_req.a   = $signed(64'(q));
        mul_req.b   = $signed(64'(q) + 64'(ud[0]));
        mul_req.sh  = 6'd0;
        ret_nxt     = S_WL_ACC;
        state_nxt   = S_MWAIT;
      end
      S_WL_ACC: begin
        sum_nxt = sum_r + 64'(mul_res);
        if (k_r == 2'd2) begin
          sqrt_start = 1'b1;
          sqrt_arg   = sum_nxt;
          ret_nxt    = S_WL_DONE;
          state_nxt  = S_SWAIT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_WL;
        end
      end
      S_WL_DONE: begin
        dl_nxt    = $signed(64'(home_r[wire_r])) - $signed({31'b0, sqrt_root, 1'b0});
        p_nxt     = P0_Q12;
        gsel_nxt  = 1'b0;
        state_nxt = S_G;
      end
      // spiral term g(p) = p*sqrt(p^2+1) + asinh(p)
      S_G: begin
        mul_start  = 1'b1;
        mul_req.a  = p_r;
        mul_req.b  = p_r;
        mul_req.sh = 6'd0;
        ret_nxt    = S_G_RT;
        state_nxt  = S_MWAIT;
      end
      S_G_RT: begin
        sqrt_start = 1'b1;
        sqrt_arg   = 64'(mul_res) + 64'(ONE_Q24);
        ret_nxt    = S_G_LN0;
        state_nxt  = S_SWAIT;
      end
      S_G_LN0: begin
        s_nxt     = sqrt_root;
        m_nxt     = 33'(ap + 64'(sqrt_root));
        n_nxt     = 7'sd30;
        frac_nxt  = '0;
        j_nxt     = '0;
        state_nxt = S_G_NORM;
      end
      // bring the mantissa into [2^30, 2^31)
      S_G_NORM: begin
        priority if (m_r == '0) begin
          mul_start  = 1'b1;
          mul_req.a  = '0;
          mul_req.b  = LN2_Q32;
          mul_req.sh = 6'd32;
          ret_nxt    = S_G_PS;
          state_nxt  = S_MWAIT;
        end else if (m_r[32:31] != 2'b00) begin
          m_nxt = m_r >> 1;
          n_nxt = n_r + 7'sd1;
        end else if (!m_r[30]) begin
          m_nxt = m_r << 1;
          n_nxt = n_r - 7'sd1;
        end else begin
          mul_start  = 1'b1;
          mul_req.a  = $signed(64'(m_r));
          mul_req.b  = $signed(64'(m_r));
          mul_req.sh = 6'd30;
          ret_nxt    = S_G_SQ;
          state_nxt  = S_MWAIT;
        end
      end
      // one fraction bit of log2 per squaring
      S_G_SQ: begin
        m_nxt     = m_sq;
        frac_nxt  = frac_sq;
        j_nxt     = j_r + 5'd1;
        mul_start = 1'b1;
        ret_nxt   = (j_r == 5'd23) ? S_G_PS : S_G_SQ;
        state_nxt = S_MWAIT;
        if (j_r == 5'd23) begin
          mul_req.a  = ln_arg;
          mul_req.b  = LN2_Q32;
          mul_req.sh = 6'd32;
        end else begin
          mul_req.a  = $signed(64'(m_sq));
          mul_req.b  = $signed(64'(m_sq));
          mul_req.sh = 6'd30;
        end
      end
      S_G_PS: begin
        ash_nxt    = mul_res;
        mul_start  = 1'b1;
        mul_req.a  = p_r;
        mul_req.b  = $signed(64'(s_r));
        mul_req.sh = 6'd0;
        ret_nxt    = S_G_END;
        state_nxt  = S_MWAIT;
      end
      S_G_END: begin
        if (!gsel_r) begin
          g0_nxt    = g_val;
          x_nxt     = '0;
          err_nxt   = -dl_r;
          iter_nxt  = '0;
          state_nxt = S_L_ES;
        end else begin
          mul_start  = 1'b1;
          mul_req.a  = g_val - g0_r;
          mul_req.b  = C_Q56;
          mul_req.sh = 6'd57;
          ret_nxt    = S_L_ERR;
          state_nxt  = S_MWAIT;
        end
      end
      // descent step
      S_L_ES: begin
        mul_start  = 1'b1;
        mul_req.a  = err_r;
        mul_req.b  = $signed(64'(s_r));
        mul_req.sh = 6'd12;
        ret_nxt    = S_L_V;
        state_nxt  = S_MWAIT;
      end
      S_L_V: begin
        mul_start  = 1'b1;
        mul_req.a  = mul_res;
        mul_req.b  = C_Q56;
        mul_req.sh = 6'd56;
        ret_nxt    = S_L_DX;
        state_nxt  = S_MWAIT;
      end
      S_L_DX: begin
        mul_start  = 1'b1;
        mul_req.a  = mul_res;
        mul_req.b  = STEP_GAIN_Q26;
        mul_req.sh = 6'd38;
        ret_nxt    = S_L_X;
        state_nxt  = S_MWAIT;
      end
      S_L_X: begin
        priority if (x_diff > 65'(X_LIMIT)) x_nxt = X_LIMIT;
        else if (x_diff < -65'(X_LIMIT))    x_nxt = -X_LIMIT;
        else                                x_nxt = x_diff[63:0];
        p_nxt     = P0_Q12 + x_nxt;
        gsel_nxt  = 1'b1;
        state_nxt = S_G;
      end
      S_L_ERR: begin
        err_nxt = err_val;
        if (err_val > -ONE_Q24 && err_val < ONE_Q24) begin
          mul_start  = 1'b1;
          mul_req.a  = err_val;
          mul_req.b  = err_val;
          mul_req.sh = 6'd0;
          ret_nxt    = S_L_TOL;
          state_nxt  = S_MWAIT;
        end else begin
          state_nxt = S_L_NEXT;
        end
      end
      S_L_TOL: begin
        state_nxt = (mul_res < TOL_Q48) ? S_CNT : S_L_NEXT;
      end
      S_L_NEXT: begin
        if (iter_r == ITER_LAST) begin
          state_nxt = S_CNT;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_L_ES;
        end
      end
      // count = trunc(x * counts per turn / 2pi)
      S_CNT: begin
        mul_start  = 1'b1;
        mul_req.a  = x_r;
        mul_req.b  = 64'(COUNTS_PER_TURN);
        mul_req.sh = 6'd0;
        ret_nxt    = S_CNT2;
        state_nxt  = S_MWAIT;
      end
      S_CNT2: begin
        mul_start  = 1'b1;
        mul_req.a  = mul_res;
        mul_req.b  = INV_2PI_Q32;
        mul_req.sh = 6'd44;
        ret_nxt    = S_CNT3;
        state_nxt  = S_MWAIT;
      end
      S_CNT3: begin
        cnt_we = 1'b1;
        priority if (mul_res > CNT_MAX) cnt_nxt = CNT_MAX[23:0];
        else if (mul_res < CNT_MIN)     cnt_nxt = CNT_MIN[23:0];
        else                            cnt_nxt = mul_res[23:0];
        if (!wire_r) begin
          wire_nxt  = 1'b1;
          k_nxt     = 2'd0;
          sum_nxt   = '0;
          state_nxt = S_WL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // hand over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {cnt_r[1], cnt_r[0]};
          state_nxt     = S_IDLE;
        end
      end
      S_MWAIT: begin
        if (mul_done) state_nxt = ret_r;
      end
      S_SWAIT: begin
        if (sqrt_done) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      wire_r      <= 1'b0;
      k_r         <= 2'd0;
      iter_r      <= '0;
      gsel_r      <= 1'b0;
      j_r         <= '0;
      x_r         <= '0;
      for (int i = 0; i < 6; i++) pul_r[i] <= '0;
      home_r[0]   <= '0;
      home_r[1]   <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      wire_r      <= wire_nxt;
      k_r         <= k_nxt;
      iter_r      <= iter_nxt;
      gsel_r      <= gsel_nxt;
      j_r         <= j_nxt;
      x_r         <= x_nxt;
      if (cfg_we) begin
        priority if (cfg_addr == REG_LEFT_HOME) home_r[0] <= cfg_wdata[30:0];
        else if (cfg_addr == REG_RIGHT_HOME)    home_r[1] <= cfg_wdata[30:0];
        else                                    pul_r[cfg_addr] <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      t_r[0] <= in_tdata[31:0];
      t_r[1] <= in_tdata[63:32];
      t_r[2] <= in_tdata[95:64];
    end
    sum_r      <= sum_nxt;
    dl_r       <= dl_nxt;
    p_r        <= p_nxt;
    ash_r      <= ash_nxt;
    g0_r       <= g0_nxt;
    err_r      <= err_nxt;
    s_r        <= s_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
    if (cnt_we) cnt_r[wire_r] <= cnt_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // every multiplier or root request is followed by a wait for its result
  a_mul_wait : assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> (state_r == S_MWAIT))
    else $error("multiplier request without wait");

  a_sqrt_wait : assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |=> (state_r == S_SWAIT))
    else $error("root request without wait");

  a_x_range : assert property (@(posedge clk) disable iff (!rst_n)
    (x_r <= X_LIMIT) && (x_r >= -X_LIMIT))
    else $error("spool angle beyond its limit");

  a_start_left : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_WL) && !wire_r && (k_r == 2'd0))
    else $error("request did not start on the left wire");

  a_iter_range : assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= ITER_LAST)
    else $error("descent step count overran");

endmodule

### tb/sv/cable_spool_inverse_kinematics_tb.sv
`timescale 1ns / 100ps

module cable_spool_inverse_kinematics_tb;
  import csik_pkg::*;

  // block parameters, left at the defaults of the top level
  localparam int WIRE_UM      = 1000;
  localparam int MAX_STEPS    = 100;
  localparam int COUNTS_TURN  = 7400;
  localparam int HOLD_CYCLES  = 120000;  // long receiver hold-off, outlasts two requests
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;    // target_x, target_y, target_z
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // left_count, right_count
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // register indexes as listed for the block
  typedef enum logic [2:0] {
    R_LEFT_X, R_LEFT_Y, R_LEFT_Z, R_RIGHT_X, R_RIGHT_Y, R_RIGHT_Z, R_LEFT_HOME, R_RIGHT_HOME
  } reg_idx_e;

  cable_spool_inverse_kinematics #(
    .WIRE_DIAMETER_UM(WIRE_UM),
    .MAX_ITERATIONS(MAX_STEPS),
    .COUNTS_PER_TURN(COUNTS_TURN)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // spool count predictor and store of pending counts
  class spool_scoreboard;
    typedef struct {
      logic [23:0] left;
      logic [23:0] right;
    } counts_t;

    counts_t     pending_q[$];
    logic [31:0] regs[8];
    int          errors;
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      // home lengths keep only 31 bits
      if (idx >= R_LEFT_HOME) regs[idx] = val & 32'h7FFF_FFFF;
      else regs[idx] = val;
    endfunction

    // exact |a|*|b| >> sh, truncated toward zero, saturated
    function automatic longint mul_shr(longint a, longint b, int sh);
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      longint       res;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      prod = ({64'd0, ua} * {64'd0, ub}) >> sh;
      if (prod > 128'h7FFF_FFFF_FFFF_FFFF) res = 64'h7FFF_FFFF_FFFF_FFFF;
      else res = prod[63:0];
      return ((a < 0) != (b < 0)) ? -res : res;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    // natural log of a q.12 value, q.24 result, log2 by repeated squaring
    function automatic longint ln_q24(logic [63:0] v);
      int          n;
      logic [63:0] m, frac;
      n = 63;
      frac = 0;
      if (v == 0) return 0;
      while (n > 0 && v[n] == 1'b0) n--;
      m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      return mul_shr(longint'(n - 12) * ONE_Q24 + longint'(frac), LN2_Q32, 32);
    endfunction

    // spiral term p*sqrt(p^2+1) + asinh(p), also hands back the root
    function automatic longint spiral_term(longint p, output longint root);
      logic [63:0] ap, s;
      longint      ash;
      ap = (p < 0) ? -p : p;
      s = root64(ap * ap + 64'd16777216);
      ash = ln_q24(ap + s);
      root = s;
      return p * longint'(s) + ((p < 0) ? -ash : ash);
    endfunction

    // length halved per axis then doubled, so the lowest bit may go
    function automatic longint wire_len(longint tx, longint ty, longint tz, int base);
      longint      t[3];
      longint      d;
      logic [63:0] ud, q, sum;
      t[0] = tx; t[1] = ty; t[2] = tz;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        d = t[i] - longint'($signed(regs[base + i]));
        ud = (d < 0) ? -d : d;
        q = ud >> 1;
        sum += q * q + q * ud[0];
      end
      return longint'(root64(sum) << 1);
    endfunction

    // descent on the spool angle until the arc length meets the change
    function automatic logic [23:0] spool_count(longint dl);
      longint c, p0, s, x, err, g0, es, v, cnt;
      c = C_Q56_UM * WIRE_UM;
      p0 = PHI0_Q12_UM / WIRE_UM;
      x = 0;
      err = -dl;
      g0 = spiral_term(p0, s);
      for (int i = 0; i < MAX_STEPS; i++) begin
        es = mul_shr(err, s, 12);
        v = mul_shr(es, c, 56);
        x -= mul_shr(v, STEP_GAIN_Q26, 38);
        if (x > X_LIMIT) x = X_LIMIT;
        if (x < -X_LIMIT) x = -X_LIMIT;
        err = mul_shr(spiral_term(p0 + x, s) - g0, c, 57) - dl;
        if (err > -ONE_Q24 && err < ONE_Q24 && err * err < TOL_Q48) break;
      end
      cnt = mul_shr(x * COUNTS_TURN, INV_2PI_Q32, 44);
      if (cnt > CNT_MAX) cnt = CNT_MAX;
      if (cnt < CNT_MIN) cnt = CNT_MIN;
      return cnt[23:0];
    endfunction

    function void note_request(logic [95:0] data);
      longint  tx, ty, tz;
      counts_t exp_c;
      tx = $signed(data[31:0]);
      ty = $signed(data[63:32]);
      tz = $signed(data[95:64]);
      exp_c.left  = spool_count(longint'(regs[R_LEFT_HOME]) - wire_len(tx, ty, tz, 0));
      exp_c.right = spool_count(longint'(regs[R_RIGHT_HOME]) - wire_len(tx, ty, tz, 3));
      pending_q.push_back(exp_c);
    endfunction

    function void check_result(logic [47:0] data);
      counts_t exp_c;
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", data);
        return;
      end
      exp_c = pending_q.pop_front();
      if (data[23:0] !== exp_c.left) begin
        errors++;
        if (mismatches++ < 10)
          $display("left_count: expected %h, got %h", exp_c.left, data[23:0]);
      end
      if (data[47:24] !== exp_c.right) begin
        errors++;
        if (mismatches++ < 10)
          $display("right_count: expected %h, got %h", exp_c.right, data[47:24]);
      end
    endfunction
  endclass

  spool_scoreboard sb = new();

  bit quiet;      // last part of the run: no idling on either side
  bit hold_req;   // ask the receiver for one long hold-off

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    int held;
    burst = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // a burst of register writes, enable dropped after the last one
  task automatic write_regs(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[2:0];
      cfg_wdata <= vals[i];
      sb.set_reg(reg_idx_e'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // offer one request, hold it until taken, then maybe idle a while
  task automatic send_target(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    in_tvalid <= 1'b1;
    in_tdata  <= {tz, ty, tx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // a point within about one metre of the origin
  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  initial begin
    logic [31:0] vals[8];
    logic [31:0] corner[6];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at reset: pulleys at the origin, zero home lengths
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1};
    foreach (corner[i]) send_target(corner[i], corner[i], corner[i]);
    send_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_target(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    wait_idle();

    // extreme pulleys, home length with bit 31 set and a zero home length
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
    write_regs(vals);
    send_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_target(32'h0, 32'h0, 32'h0);
    send_target(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_0000);
    wait_idle();

    // a working rig: pulleys either side overhead, home near the working distance
    vals = '{-32'sd16777216, 32'd0, 32'd33554432, 32'd16777216, 32'd0, 32'd33554432,
             32'd39000000, 32'd37500000};
    write_regs(vals);
    for (int n = 0; n < 140; n++) begin
      if (n == 30) hold_req = 1'b1;   // receiver stalls, input backs up
      if (n == 70) begin
        // sender pauses for a full drain, then the rig changes
        wait_idle();
        vals = '{32'd8388608, -32'sd25165824, 32'd50331648, -32'sd8388608, 32'd25165824,
                 32'd16777216, 32'd30000000, 32'd48000000};
        write_regs(vals);
      end
      if (n == 115) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send_target($urandom, $urandom, $urandom);
      else
        send_target(near_coord(), near_coord(), near_coord());
    end

    wait_idle();
    if (sb.errors == 0)
      $display("cable_spool_inverse_kinematics verification clean");
    else
      $display("cable_spool_inverse_kinematics verification failed");
    $finish;
  end

  // overall limit, set well above the slowest correct run
  initial begin
    #400_000_000;
    $display("cable_spool_inverse_kinematics verification failed");
    $finish;
  end

endmodule
